[hdl/lcfs_schedule_metrics_defines.svh]
// assertion macros for the lcfs schedule metrics block
// used by modules that carry concurrent checks; no other dependencies
`ifndef LCFS_SCHEDULE_METRICS_DEFINES_SVH
`define LCFS_SCHEDULE_METRICS_DEFINES_SVH
`ifndef SYNTHESIS
`define LCFS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcfs check failed");
`define LCFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcfs check failed");
`else
`define LCFS_ASSERT_IMP(label, clk, rst, ante, cons)
`define LCFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/lcfs_pkg.sv]
// shared widths, types and codes for the lcfs schedule metrics block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lcfs_pkg;
  localparam int MAX_PROCS_DEF = 16;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 21;
  localparam int TOT_W   = 25;
  localparam int ID_W    = 5;
  localparam int KEY_W   = ARR_W + ID_W;
  localparam int ALU_W   = TOT_W;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MAX,
    ALU_CMP
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] value;
    logic             gt;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SCAN,
    S_CALC_MAX,
    S_CALC_CT,
    S_CALC_TAT,
    S_CALC_WT,
    S_TOT_TAT,
    S_TOT_WT,
    S_EMIT
  } state_t;
endpackage
`default_nettype wire

[hdl/lcfs_alu.sv]
// shared add / subtract / max / compare unit
// depends on lcfs_pkg
`timescale 1ns / 1ps
`default_nettype none
module lcfs_alu (
  input  lcfs_pkg::alu_req_t req,
  output lcfs_pkg::alu_rsp_t rsp
);
  import lcfs_pkg::*;

  logic a_gt_b;

  always_comb begin
    a_gt_b = req.a > req.b;
    rsp.gt = a_gt_b;
    case (req.op)
      ALU_ADD: rsp.value = req.a + req.b;
      ALU_SUB: rsp.value = req.a - req.b;
      ALU_MAX: rsp.value = a_gt_b ? req.a : req.b;
      ALU_CMP: rsp.value = ALU_W'(a_gt_b);
      default: rsp.value = req.a + req.b;
    endcase
  end
endmodule
`default_nettype wire

[hdl/lcfs_store.sv]
// process store: arrival and burst per slot, one write and one registered read port
// depends on lcfs_pkg
`timescale 1ns / 1ps
`default_nettype none
module lcfs_store #(
  parameter int DEPTH = lcfs_pkg::MAX_PROCS_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [lcfs_pkg::ARR_W-1:0]  wr_arrival,
  input  logic [lcfs_pkg::BURST_W-1:0] wr_burst,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [lcfs_pkg::ARR_W-1:0]  rd_arrival,
  output logic [lcfs_pkg::BURST_W-1:0] rd_burst
);
  import lcfs_pkg::*;

  logic [ARR_W+BURST_W-1:0] mem [DEPTH];
  logic [ARR_W+BURST_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_arrival, wr_burst};
    end
    rd_word <= mem[rd_addr];
  end

  assign rd_arrival = rd_word[ARR_W+BURST_W-1:BURST_W];
  assign rd_burst   = rd_word[BURST_W-1:0];
endmodule
`default_nettype wire

[hdl/lcfs_seq.sv]
// sequencer: load, selection scan and metric steps through the shared alu
// depends on lcfs_pkg and lcfs_schedule_metrics_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "lcfs_schedule_metrics_defines.svh"
module lcfs_seq #(
  parameter int MAX_PROCS = lcfs_pkg::MAX_PROCS_DEF,
  localparam int IDXW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  localparam int CNTW = $clog2(MAX_PROCS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lcfs_pkg::ARR_W-1:0]   arrival_time,
  input  logic [lcfs_pkg::BURST_W-1:0] burst_time,
  input  logic                         last_item,
  output logic                         wr_en,
  output logic [IDXW-1:0]              wr_addr,
  output logic [lcfs_pkg::ARR_W-1:0]   wr_arrival,
  output logic [lcfs_pkg::BURST_W-1:0] wr_burst,
  output logic [IDXW-1:0]              rd_addr,
  input  logic [lcfs_pkg::ARR_W-1:0]   rd_arrival,
  input  logic [lcfs_pkg::BURST_W-1:0] rd_burst,
  output lcfs_pkg::alu_req_t           alu_req,
  input  lcfs_pkg::alu_rsp_t           alu_rsp,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcfs_pkg::ID_W-1:0]    process_id,
  output logic [lcfs_pkg::ARR_W-1:0]   arrival_out,
  output logic [lcfs_pkg::BURST_W-1:0] burst_out,
  output logic [lcfs_pkg::TIME_W-1:0]  completion_time,
  output logic [lcfs_pkg::TIME_W-1:0]  turnaround_time,
  output logic [lcfs_pkg::TIME_W-1:0]  waiting_time,
  output logic [lcfs_pkg::TOT_W-1:0]   total_turnaround,
  output logic [lcfs_pkg::TOT_W-1:0]   total_waiting,
  output logic [lcfs_pkg::ID_W-1:0]    process_count,
  output logic                         last_result
);
  import lcfs_pkg::*;

  state_t state, state_next;

  logic [CNTW-1:0]      loaded_cnt;
  logic [CNTW-1:0]      emit_cnt;
  logic [CNTW-1:0]      scan_idx;
  logic                 cmp_vld;
  logic [IDXW-1:0]      cmp_slot;
  logic [IDXW:0]        cmp_id_full;
  logic [ID_W-1:0]      cmp_id;
  logic [KEY_W-1:0]     cmp_key;
  logic                 best_found;
  logic [IDXW-1:0]      best_slot;
  logic [ARR_W-1:0]     best_arr;
  logic [BURST_W-1:0]   best_burst;
  logic [ID_W-1:0]      best_id;
  logic [MAX_PROCS-1:0] used;
  logic [TIME_W-1:0]    cur_time;
  logic [TIME_W-1:0]    tat;
  logic [TIME_W-1:0]    wt;
  logic [TOT_W-1:0]     tot_tat;
  logic [TOT_W-1:0]     tot_wt;

  logic in_take;
  logic has_room;
  logic scan_issue;
  logic scan_done;
  logic cmp_take;
  logic out_free;
  logic emit_last;

  assign in_stall   = (state != S_LOAD);
  assign in_take    = in_valid && !in_stall;
  assign has_room   = loaded_cnt < CNTW'(MAX_PROCS);
  assign scan_issue = scan_idx < loaded_cnt;
  assign scan_done  = !scan_issue && !cmp_vld;
  assign out_free   = !out_valid || !out_stall;
  assign emit_last  = (emit_cnt + CNTW'(1)) == loaded_cnt;

  // id is the 1-based load index, kept to 5 bits
  assign cmp_id_full = {1'b0, cmp_slot} + (IDXW+1)'(1);
  assign cmp_id      = ID_W'(cmp_id_full);
  assign cmp_key     = {rd_arrival, cmp_id};
  // strict compare while scanning upward keeps the earlier slot on equal keys
  assign cmp_take    = cmp_vld && !used[cmp_slot] && (!best_found || alu_rsp.gt);

  assign wr_en      = in_take && has_room;
  assign wr_addr    = loaded_cnt[IDXW-1:0];
  assign wr_arrival = arrival_time;
  assign wr_burst   = burst_time;
  assign rd_addr    = scan_idx[IDXW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_req    = '0;
    case (state)
      S_LOAD: begin
        if (in_take && last_item) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        alu_req.op = ALU_CMP;
        alu_req.a  = ALU_W'(cmp_key);
        alu_req.b  = ALU_W'({best_arr, best_id});
        if (scan_done) begin
          state_next = S_CALC_MAX;
        end
      end
      S_CALC_MAX: begin
        // idle cpu jumps ahead to the arrival
        alu_req.op = ALU_MAX;
        alu_req.a  = ALU_W'(cur_time);
        alu_req.b  = ALU_W'(best_arr);
        state_next = S_CALC_CT;
      end
      S_CALC_CT: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(cur_time);
        alu_req.b  = ALU_W'(best_burst);
        state_next = S_CALC_TAT;
      end
      S_CALC_TAT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(cur_time);
        alu_req.b  = ALU_W'(best_arr);
        state_next = S_CALC_WT;
      end
      S_CALC_WT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(tat);
        alu_req.b  = ALU_W'(best_burst);
        state_next = S_TOT_TAT;
      end
      S_TOT_TAT: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(tot_tat);
        alu_req.b  = ALU_W'(tat);
        state_next = S_TOT_WT;
      end
      S_TOT_WT: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(tot_wt);
        alu_req.b  = ALU_W'(wt);
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = emit_last ? S_LOAD : S_SCAN;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_cnt <= '0;
      emit_cnt   <= '0;
      scan_idx   <= '0;
      cmp_vld    <= 1'b0;
      best_found <= 1'b0;
      used       <= '0;
      cur_time   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_take) begin
            if (has_room) begin
              loaded_cnt <= loaded_cnt + CNTW'(1);
            end
            if (last_item) begin
              emit_cnt   <= '0;
              used       <= '0;
              scan_idx   <= '0;
              cmp_vld    <= 1'b0;
              best_found <= 1'b0;
              cur_time   <= '0;
            end
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            scan_idx <= scan_idx + CNTW'(1);
            cmp_vld  <= 1'b1;
          end else begin
            cmp_vld <= 1'b0;
          end
          if (cmp_take) begin
            best_found <= 1'b1;
          end
        end
        S_CALC_MAX: begin
          cur_time <= alu_rsp.value[TIME_W-1:0];
        end
        S_CALC_CT: begin
          cur_time <= alu_rsp.value[TIME_W-1:0];
        end
        S_TOT_WT: begin
          used[best_slot] <= 1'b1;
        end
        S_EMIT: begin
          if (out_free) begin
            emit_cnt  <= emit_cnt + CNTW'(1);
            if (emit_last) begin
              loaded_cnt <= '0;
              cur_time   <= '0;
            end else begin
              scan_idx   <= '0;
              cmp_vld    <= 1'b0;
              best_found <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        if (in_take && last_item) begin
          tot_tat <= '0;
          tot_wt  <= '0;
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          cmp_slot <= scan_idx[IDXW-1:0];
        end
        if (cmp_take) begin
          best_slot  <= cmp_slot;
          best_arr   <= rd_arrival;
          best_burst <= rd_burst;
          best_id    <= cmp_id;
        end
      end
      S_CALC_TAT: begin
        tat <= alu_rsp.value[TIME_W-1:0];
      end
      S_CALC_WT: begin
        wt <= alu_rsp.value[TIME_W-1:0];
      end
      S_TOT_TAT: begin
        tot_tat <= alu_rsp.value[TOT_W-1:0];
      end
      S_TOT_WT: begin
        tot_wt <= alu_rsp.value[TOT_W-1:0];
      end
      S_EMIT: begin
        if (out_free) begin
          process_id       <= best_id;
          arrival_out      <= best_arr;
          burst_out        <= best_burst;
          completion_time  <= cur_time;
          turnaround_time  <= tat;
          waiting_time     <= wt;
          total_turnaround <= tot_tat;
          total_waiting    <= tot_wt;
          process_count    <= ID_W'(loaded_cnt);
          last_result      <= emit_last;
        end
      end
      default: begin
      end
    endcase
  end

  `LCFS_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, loaded_cnt <= CNTW'(MAX_PROCS))
  `LCFS_ASSERT_IMP(a_emit_below, clk, rst, state != S_LOAD, emit_cnt < loaded_cnt)
  `LCFS_ASSERT_IMP(a_used_match, clk, rst, state == S_SCAN, $countones(used) == int'(emit_cnt))
  `LCFS_ASSERT_NEXT(a_set_close, clk, rst, state == S_EMIT && out_free && emit_last, state == S_LOAD && loaded_cnt == '0 && out_valid)
endmodule
`default_nettype wire

[hdl/lcfs_schedule_metrics.sv]
// top level of the lcfs schedule metrics block
// depends on lcfs_pkg, lcfs_alu, lcfs_store and lcfs_seq
//
//   channel | signals                     | direction
//   input   | in_valid, in_stall, fields  | one process per transfer
//   output  | out_valid, out_stall, fields| one scheduled process per transfer
//
// loading accepts one process per cycle; the set closes with last_item
// each result then takes a scan of the loaded slots of the store
//   through its one read port, then six steps on the single shared alu
// loading resumes once the last result of the set has been emitted
// rst is synchronous; it clears the loaded count and returns to loading
// a stalled result holds the sequencer in its emit step until the transfer
`timescale 1ns / 1ps
`default_nettype none
module lcfs_schedule_metrics #(
  parameter int MAX_PROCS = lcfs_pkg::MAX_PROCS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lcfs_pkg::ARR_W-1:0]   arrival_time,
  input  logic [lcfs_pkg::BURST_W-1:0] burst_time,
  input  logic                         last_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcfs_pkg::ID_W-1:0]    process_id,
  output logic [lcfs_pkg::ARR_W-1:0]   arrival_out,
  output logic [lcfs_pkg::BURST_W-1:0] burst_out,
  output logic [lcfs_pkg::TIME_W-1:0]  completion_time,
  output logic [lcfs_pkg::TIME_W-1:0]  turnaround_time,
  output logic [lcfs_pkg::TIME_W-1:0]  waiting_time,
  output logic [lcfs_pkg::TOT_W-1:0]   total_turnaround,
  output logic [lcfs_pkg::TOT_W-1:0]   total_waiting,
  output logic [lcfs_pkg::ID_W-1:0]    process_count,
  output logic                         last_result
);
  import lcfs_pkg::*;

  localparam int IDXW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

  logic                wr_en;
  logic [IDXW-1:0]     wr_addr;
  logic [ARR_W-1:0]    wr_arrival;
  logic [BURST_W-1:0]  wr_burst;
  logic [IDXW-1:0]     rd_addr;
  logic [ARR_W-1:0]    rd_arrival;
  logic [BURST_W-1:0]  rd_burst;
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  lcfs_store #(
    .DEPTH(MAX_PROCS)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_arrival(wr_arrival),
    .wr_burst  (wr_burst),
    .rd_addr   (rd_addr),
    .rd_arrival(rd_arrival),
    .rd_burst  (rd_burst)
  );

  lcfs_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  lcfs_seq #(
    .MAX_PROCS(MAX_PROCS)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .arrival_time    (arrival_time),
    .burst_time      (burst_time),
    .last_item       (last_item),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_arrival      (wr_arrival),
    .wr_burst        (wr_burst),
    .rd_addr         (rd_addr),
    .rd_arrival      (rd_arrival),
    .rd_burst        (rd_burst),
    .alu_req         (alu_req),
    .alu_rsp         (alu_rsp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .process_id      (process_id),
    .arrival_out     (arrival_out),
    .burst_out       (burst_out),
    .completion_time (completion_time),
    .turnaround_time (turnaround_time),
    .waiting_time    (waiting_time),
    .total_turnaround(total_turnaround),
    .total_waiting   (total_waiting),
    .process_count   (process_count),
    .last_result     (last_result)
  );
endmodule
`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for lcfs_schedule_metrics: loads directed and random process sets and
// checks every scheduled result against an in-bench last-come-first-serve predictor
// depends on lcfs_pkg and the lcfs_schedule_metrics rtl
`timescale 1ns / 1ps
module tb_top;
  import lcfs_pkg::*;

  localparam int SET_DEPTH = MAX_PROCS_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int TARGET_PROCS = 410;
  localparam int QUIET_TAIL = 60;

  typedef struct {
    logic [ID_W-1:0]    pid;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  completion;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic [TOT_W-1:0]   sum_turnaround;
    logic [TOT_W-1:0]   sum_waiting;
    logic [ID_W-1:0]    set_size;
    logic               final_flag;
  } sched_result_t;

  class lcfs_scoreboard;
    logic [ARR_W-1:0]   arr_mem[SET_DEPTH];
    logic [BURST_W-1:0] burst_mem[SET_DEPTH];
    logic [ID_W-1:0]    id_mem[SET_DEPTH];
    int unsigned        loaded;
    sched_result_t      pending[$];
    int unsigned        errors;

    function new();
      loaded = 0;
      errors = 0;
    endfunction

    // latest arrival first, larger id first on a tie
    function bit runs_first(int unsigned x, int unsigned y);
      if (arr_mem[x] != arr_mem[y]) return arr_mem[x] > arr_mem[y];
      return id_mem[x] > id_mem[y];
    endfunction

    function void note_process(logic [ARR_W-1:0] at, logic [BURST_W-1:0] bt, logic last);
      int unsigned order[SET_DEPTH];
      int unsigned t, j, s;
      logic [TIME_W-1:0] now_t, ct, tat, wt;
      logic [TOT_W-1:0] tot_t, tot_w;
      sched_result_t r;
      if (loaded < SET_DEPTH) begin
        arr_mem[loaded] = at;
        burst_mem[loaded] = bt;
        id_mem[loaded] = ID_W'(loaded + 1);
        loaded++;
      end
      if (!last) return;
      for (int unsigned i = 0; i < loaded; i++) order[i] = i;
      for (int unsigned i = 1; i < loaded; i++) begin
        t = order[i];
        j = i;
        while (j > 0 && runs_first(t, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = t;
      end
      now_t = '0;
      tot_t = '0;
      tot_w = '0;
      for (int unsigned k = 0; k < loaded; k++) begin
        s = order[k];
        if (TIME_W'(arr_mem[s]) > now_t) now_t = TIME_W'(arr_mem[s]);
        ct = now_t + TIME_W'(burst_mem[s]);
        now_t = ct;
        tat = ct - TIME_W'(arr_mem[s]);
        wt = tat - TIME_W'(burst_mem[s]);
        tot_t = tot_t + TOT_W'(tat);
        tot_w = tot_w + TOT_W'(wt);
        r.pid = id_mem[s];
        r.arrival = arr_mem[s];
        r.burst = burst_mem[s];
        r.completion = ct;
        r.turnaround = tat;
        r.waiting = wt;
        r.sum_turnaround = tot_t;
        r.sum_waiting = tot_w;
        r.set_size = ID_W'(loaded);
        r.final_flag = (k + 1 == loaded);
        pending.push_back(r);
      end
      loaded = 0;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual process_id %0d",
                 $time, got.pid);
        return;
      end
      want = pending.pop_front();
      compare_field("process_id", 32'(want.pid), 32'(got.pid));
      compare_field("arrival_out", 32'(want.arrival), 32'(got.arrival));
      compare_field("burst_out", 32'(want.burst), 32'(got.burst));
      compare_field("completion_time", 32'(want.completion), 32'(got.completion));
      compare_field("turnaround_time", 32'(want.turnaround), 32'(got.turnaround));
      compare_field("waiting_time", 32'(want.waiting), 32'(got.waiting));
      compare_field("total_turnaround", 32'(want.sum_turnaround),
                    32'(got.sum_turnaround));
      compare_field("total_waiting", 32'(want.sum_waiting), 32'(got.sum_waiting));
      compare_field("process_count", 32'(want.set_size), 32'(got.set_size));
      compare_field("last_result", 32'(want.final_flag), 32'(got.final_flag));
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [ARR_W-1:0]    arrival_time;
  logic [BURST_W-1:0]  burst_time;
  logic                last_item;
  logic                out_valid;
  logic                out_stall;
  logic [ID_W-1:0]     process_id;
  logic [ARR_W-1:0]    arrival_out;
  logic [BURST_W-1:0]  burst_out;
  logic [TIME_W-1:0]   completion_time;
  logic [TIME_W-1:0]   turnaround_time;
  logic [TIME_W-1:0]   waiting_time;
  logic [TOT_W-1:0]    total_turnaround;
  logic [TOT_W-1:0]    total_waiting;
  logic [ID_W-1:0]     process_count;
  logic                last_result;

  lcfs_scoreboard sb;
  bit             in_idle_on;
  bit             out_idle_on;
  int unsigned    stall_left;
  int unsigned    quiet_cycles;
  int unsigned    stored_procs;

  lcfs_schedule_metrics u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .arrival_time     (arrival_time),
    .burst_time       (burst_time),
    .last_item        (last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .process_id       (process_id),
    .arrival_out      (arrival_out),
    .burst_out        (burst_out),
    .completion_time  (completion_time),
    .turnaround_time  (turnaround_time),
    .waiting_time     (waiting_time),
    .total_turnaround (total_turnaround),
    .total_waiting    (total_waiting),
    .process_count    (process_count),
    .last_result      (last_result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    sched_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.pid = process_id;
      got.arrival = arrival_out;
      got.burst = burst_out;
      got.completion = completion_time;
      got.turnaround = turnaround_time;
      got.waiting = waiting_time;
      got.sum_turnaround = total_turnaround;
      got.sum_waiting = total_waiting;
      got.set_size = process_count;
      got.final_flag = last_result;
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left--;
    end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17);
    end
    out_stall <= (stall_left > 0);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lcfs_schedule_metrics regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one process per call; returns at the edge where the transfer happens
  task automatic send_process(logic [ARR_W-1:0] at, logic [BURST_W-1:0] bt, logic last);
    int unsigned gap;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    arrival_time <= at;
    burst_time <= bt;
    last_item <= last;
    do @(posedge clk); while (in_stall);
    sb.note_process(at, bt, last);
  endtask

  task automatic send_set(int unsigned count, bit with_idle);
    logic [ARR_W-1:0]   at;
    logic [BURST_W-1:0] bt;
    int unsigned        amode, bmode;
    logic [ARR_W-1:0]   shared_arr;
    amode = $urandom_range(0, 3);
    bmode = $urandom_range(0, 3);
    shared_arr = ARR_W'($urandom);
    in_idle_on = with_idle && ($urandom_range(0, 3) != 0);
    out_idle_on <= with_idle && ($urandom_range(0, 3) != 0);
    for (int unsigned i = 0; i < count; i++) begin
      case (amode)
        0: at = ARR_W'($urandom);
        1: at = ARR_W'($urandom_range(0, 7));
        2: at = shared_arr;
        default: at = $urandom_range(0, 1) ? '1 : '0;
      endcase
      case (bmode)
        0: bt = BURST_W'($urandom);
        1: bt = BURST_W'($urandom_range(0, 3));
        2: bt = $urandom_range(0, 1) ? '1 : '0;
        default: bt = BURST_W'($urandom_range(0, 1000));
      endcase
      send_process(at, bt, i == count - 1);
    end
    stored_procs += (count > SET_DEPTH) ? SET_DEPTH : count;
  endtask

  initial begin
    int unsigned count;
    bit          first_random;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    arrival_time = '0;
    burst_time = '0;
    last_item = 1'b0;
    out_stall = 1'b0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    stall_left = 0;
    quiet_cycles = 0;
    stored_procs = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // single-process sets at both extremes
    send_process('0, '0, 1'b1);
    send_process('1, '1, 1'b1);
    // equal arrivals: larger id must go first
    send_process(16'd5, 16'd1, 1'b0);
    send_process(16'd5, 16'd2, 1'b0);
    send_process(16'd5, 16'd3, 1'b0);
    send_process(16'd5, '1, 1'b1);
    // late arrival first, clock jumps forward before it runs
    send_process(16'd0, 16'd10, 1'b0);
    send_process(16'd100, '1, 1'b0);
    send_process(16'd50000, 16'd7, 1'b1);
    // extremes mixed, ties on both ends
    send_process('1, '1, 1'b0);
    send_process('0, '1, 1'b0);
    send_process('1, '1, 1'b0);
    send_process('0, '1, 1'b1);
    stored_procs = 13;

    // random sets; first one overruns the store with last on a dropped transfer
    first_random = 1'b1;
    while (stored_procs < TARGET_PROCS) begin
      if (first_random || $urandom_range(0, 7) == 0) count = $urandom_range(17, 20);
      else if ($urandom_range(0, 5) == 0) count = SET_DEPTH;
      else count = $urandom_range(1, SET_DEPTH);
      first_random = 1'b0;
      send_set(count, stored_procs < TARGET_PROCS - QUIET_TAIL);
    end
    in_valid <= 1'b0;
    last_item <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("lcfs_schedule_metrics regression: pass");
    end else begin
      $display("lcfs_schedule_metrics regression: fail");
    end
    $finish;
  end
endmodule
